// File: sv/lnq_pkg.sv
// Package for the line assembler queue: request/result structs, command codes,
// back-end states and character constants. No dependencies.
package lnq_pkg;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic [1:0] ACT_RX_BYTE  = 2'd0;
  localparam logic [1:0] ACT_UART_ERR = 2'd1;
  localparam logic [1:0] ACT_POP      = 2'd2;

  // command queue between front and back
  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_PW    = $clog2(CMDQ_DEPTH);

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  rx_byte;
    logic [31:0] rx_time;
  } req_t;

  typedef struct packed {
    logic [7:0]  line_byte;
    logic [6:0]  line_length;
    logic [31:0] line_time;
    logic        is_last;
    logic        queue_empty;
    logic [15:0] drop_total;
  } rsp_t;

  typedef enum logic [1:0] {
    CMD_CHAR,
    CMD_LF,
    CMD_ERR,
    CMD_POP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  data;
    logic [31:0] stamp;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_POP
  } back_state_e;

endpackage

// File: sv/line_assembler_queue.sv
// Top level of the line assembler queue: front decoder, command FIFO, back end.
// Depends on lnq_pkg, lnq_front, lnq_cmdq, lnq_back.
//
//   channel   | ports                        | handshake
//   ----------+------------------------------+-------------------------------
//   request   | start_i, busy_o, req_i       | taken when start_i && !busy_o
//   result    | rsp_valid_o, rsp_o           | each result shown once, no stall
//
// A byte or error request, and a pop of an empty queue or empty line, is handled
// by the back end in its idle state; a pop of a line of L bytes goes on in the pop
// state with one line store read per cycle, each result appearing in the cycle
// after its read.
// busy_o rises only when the four-entry command FIFO is full.
// Reset clears the pointers, counters and flags; line storage is not cleared.
module line_assembler_queue import lnq_pkg::*; #(
  parameter int unsigned LINE_MAX    = 64,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  logic push;
  cmd_t front_cmd;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  lnq_front u_front (
    .start_i (start_i),
    .busy_i  (busy_o),
    .req_i   (req_i),
    .push_o  (push),
    .cmd_o   (front_cmd)
  );

  lnq_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (busy_o),
    .valid_o (q_valid),
    .cmd_o   (q_cmd),
    .pop_i   (q_pop)
  );

  lnq_back #(
    .LINE_MAX    (LINE_MAX),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

endmodule

// File: sv/lnq_front.sv
// Front end: decodes an accepted request into a back-end command.
// Carriage returns and the unused action code produce no command. Uses lnq_pkg.
module lnq_front import lnq_pkg::*; (
  input  logic start_i,
  input  logic busy_i,
  input  req_t req_i,
  output logic push_o,
  output cmd_t cmd_o
);

  logic keep;

  always_comb begin
    keep        = 1'b0;
    cmd_o.kind  = CMD_CHAR;
    cmd_o.data  = req_i.rx_byte;
    cmd_o.stamp = req_i.rx_time;
    unique case (req_i.action)
      ACT_RX_BYTE: begin
        keep       = (req_i.rx_byte != CH_CR);
        cmd_o.kind = (req_i.rx_byte == CH_LF) ? CMD_LF : CMD_CHAR;
      end
      ACT_UART_ERR: begin
        keep       = 1'b1;
        cmd_o.kind = CMD_ERR;
      end
      ACT_POP: begin
        keep       = 1'b1;
        cmd_o.kind = CMD_POP;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push_o = start_i && !busy_i && keep;

endmodule

// File: sv/lnq_cmdq.sv
// Short command FIFO between the front and back ends.
// Uses lnq_pkg for the command type and depth.
module lnq_cmdq import lnq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t cmd_o,
  input  logic pop_i
);

  cmd_t                entry_q [CMDQ_DEPTH];
  logic [CMDQ_PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [CMDQ_PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CMDQ_PW:0]    count_q, count_d;
  logic                do_pop;

  assign full_o  = (count_q == (CMDQ_PW+1)'(CMDQ_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == CMDQ_PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == CMDQ_PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// File: sv/lnq_back.sv
// Back end: assembles lines straight into the free ring slot of the line store,
// commits or drops them on line feed and streams popped lines out. Uses lnq_pkg.
module lnq_back import lnq_pkg::*; #(
  parameter int unsigned LINE_MAX    = 64,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  localparam int unsigned SW        = $clog2(QUEUE_DEPTH);
  localparam int unsigned LW        = $clog2(LINE_MAX + 1);
  localparam int unsigned IW        = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
  localparam int unsigned MEM_DEPTH = QUEUE_DEPTH * LINE_MAX;
  localparam int unsigned AW        = $clog2(MEM_DEPTH);

  back_state_e      state_q, state_d;
  logic [LW-1:0]    plen_q, plen_d;
  logic             overlong_q, overlong_d;
  logic [SW-1:0]    wslot_q, wslot_d;
  logic [SW-1:0]    rslot_q, rslot_d;
  logic [15:0]      drop_q, drop_d;
  logic [LW-1:0]    cnt_q, cnt_d;

  logic [LW-1:0]    slot_len_q  [QUEUE_DEPTH];
  logic [31:0]      slot_time_q [QUEUE_DEPTH];
  logic             slot_we;

  logic [7:0]       mem [MEM_DEPTH];
  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [7:0]       rdata_q;

  logic             stg_valid_q, stg_valid_d;
  logic             stg_mem_q, stg_mem_d;
  rsp_t             stg_q, stg_d;

  logic [SW-1:0]    wnext, rnext;
  logic [LW-1:0]    cur_len;

  function automatic logic [AW-1:0] slot_base(input logic [SW-1:0] slot);
    return AW'(slot) * AW'(LINE_MAX);
  endfunction

  assign wnext     = (wslot_q == SW'(QUEUE_DEPTH - 1)) ? '0 : wslot_q + 1'b1;
  assign rnext     = (rslot_q == SW'(QUEUE_DEPTH - 1)) ? '0 : rslot_q + 1'b1;
  assign cur_len   = slot_len_q[rslot_q];
  assign mem_waddr = slot_base(wslot_q) + AW'(plen_q[IW-1:0]);
  assign mem_raddr = slot_base(rslot_q) + AW'(cnt_q[IW-1:0]);
  assign cmd_pop_o = (state_q == BK_IDLE);

  always_comb begin
    state_d     = state_q;
    plen_d      = plen_q;
    overlong_d  = overlong_q;
    wslot_d     = wslot_q;
    rslot_d     = rslot_q;
    drop_d      = drop_q;
    cnt_d       = cnt_q;
    slot_we     = 1'b0;
    mem_we      = 1'b0;
    stg_valid_d = 1'b0;
    stg_mem_d   = 1'b0;
    stg_d       = '0;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            CMD_CHAR: begin
              if (plen_q < LW'(LINE_MAX)) begin
                mem_we = 1'b1;
                plen_d = plen_q + 1'b1;
              end else begin
                overlong_d = 1'b1;
              end
            end
            CMD_LF: begin
              if (overlong_q || wnext == rslot_q) begin
                drop_d = drop_q + 16'd1;
              end else begin
                slot_we = 1'b1;
                wslot_d = wnext;
              end
              plen_d     = '0;
              overlong_d = 1'b0;
            end
            CMD_ERR: begin
              drop_d     = drop_q + 16'd1;
              plen_d     = '0;
              overlong_d = 1'b1;
            end
            CMD_POP: begin
              if (rslot_q == wslot_q) begin
                stg_valid_d       = 1'b1;
                stg_d.queue_empty = 1'b1;
                stg_d.drop_total  = drop_q;
              end else if (cur_len == '0) begin
                stg_valid_d      = 1'b1;
                stg_d.line_time  = slot_time_q[rslot_q];
                stg_d.is_last    = 1'b1;
                stg_d.drop_total = drop_q;
                rslot_d          = rnext;
              end else begin
                cnt_d   = '0;
                state_d = BK_POP;
              end
            end
            default: ;
          endcase
        end
      end
      BK_POP: begin
        // one store read per cycle; byte lands in rdata_q with the stage
        stg_valid_d       = 1'b1;
        stg_mem_d         = 1'b1;
        stg_d.line_length = 7'(cur_len);
        stg_d.line_time   = slot_time_q[rslot_q];
        stg_d.is_last     = (cnt_q + 1'b1 == cur_len);
        stg_d.drop_total  = drop_q;
        cnt_d             = cnt_q + 1'b1;
        if (cnt_q + 1'b1 == cur_len) begin
          rslot_d = rnext;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      plen_q      <= '0;
      overlong_q  <= 1'b0;
      wslot_q     <= '0;
      rslot_q     <= '0;
      drop_q      <= '0;
      cnt_q       <= '0;
      stg_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      plen_q      <= plen_d;
      overlong_q  <= overlong_d;
      wslot_q     <= wslot_d;
      rslot_q     <= rslot_d;
      drop_q      <= drop_d;
      cnt_q       <= cnt_d;
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stg_q     <= stg_d;
    stg_mem_q <= stg_mem_d;
    if (slot_we) begin
      slot_len_q[wslot_q]  <= plen_q;
      slot_time_q[wslot_q] <= cmd_i.stamp;
    end
  end

  // line store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= cmd_i.data;
    end
    rdata_q <= mem[mem_raddr];
  end

  assign rsp_valid_o = stg_valid_q;

  always_comb begin
    rsp_o           = stg_q;
    rsp_o.line_byte = stg_mem_q ? rdata_q : 8'd0;
  end

endmodule
